[design/lbc_pkg.sv]
package lbc_pkg;

  // number format
  localparam int FRAC_BITS = 20;
  localparam int FIELD_W   = 24;
  localparam int NDIR      = 9;
  localparam int RELAX_W   = 22;

  localparam logic [RELAX_W-1:0] RELAX_RESET = RELAX_W'(1613194);

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef field_t dist_arr_t [NDIR];

  localparam field_t FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam field_t FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  // direction order (rest, e, w, n, s, ne, nw, sw, se)
  localparam int DIR_REST  = 0;
  localparam int DIR_EAST  = 1;
  localparam int DIR_WEST  = 2;
  localparam int DIR_NORTH = 3;
  localparam int DIR_SOUTH = 4;
  localparam int DIR_NE    = 5;
  localparam int DIR_NW    = 6;
  localparam int DIR_SW    = 7;
  localparam int DIR_SE    = 8;

  // moment sums and velocity divider
  localparam int SUM_W     = FIELD_W + 4;
  localparam int MAG_W     = SUM_W - 1;
  localparam int QUO_W     = FIELD_W;
  localparam int REM_W     = FIELD_W;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;
  localparam int DIV_LAT   = DIV_STAGES + 2;

  // equilibrium datapath widths
  localparam int VS_W  = FIELD_W + 1;
  localparam int SQ_W  = 2 * VS_W;
  localparam int E_W   = SQ_W + 4;
  localparam int T3_W  = VS_W + 3;
  localparam int LANE_LAT = 10;

  // weight classes of the nine directions
  typedef enum logic [1:0] {
    WT_REST,
    WT_AXIS,
    WT_DIAG
  } wt_t;

  function automatic wt_t lane_wt(input int k);
    wt_t w;
    if (k == DIR_REST) w = WT_REST;
    else if (k < DIR_NE) w = WT_AXIS;
    else w = WT_DIAG;
    return w;
  endfunction

  // clamp a wide signed value into the field range
  function automatic field_t sat_field(input logic signed [63:0] x);
    field_t r;
    if (x > 64'(FIELD_MAX)) r = FIELD_MAX;
    else if (x < 64'(FIELD_MIN)) r = FIELD_MIN;
    else r = x[FIELD_W-1:0];
    return r;
  endfunction

  typedef struct packed {
    logic signed [FIELD_W-1:0] dist_rest;
    logic signed [FIELD_W-1:0] dist_east;
    logic signed [FIELD_W-1:0] dist_west;
    logic signed [FIELD_W-1:0] dist_north;
    logic signed [FIELD_W-1:0] dist_south;
    logic signed [FIELD_W-1:0] dist_ne;
    logic signed [FIELD_W-1:0] dist_nw;
    logic signed [FIELD_W-1:0] dist_sw;
    logic signed [FIELD_W-1:0] dist_se;
  } cell_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] post_rest;
    logic signed [FIELD_W-1:0] post_east;
    logic signed [FIELD_W-1:0] post_west;
    logic signed [FIELD_W-1:0] post_north;
    logic signed [FIELD_W-1:0] post_south;
    logic signed [FIELD_W-1:0] post_ne;
    logic signed [FIELD_W-1:0] post_nw;
    logic signed [FIELD_W-1:0] post_sw;
    logic signed [FIELD_W-1:0] post_se;
    logic signed [FIELD_W-1:0] density;
    logic signed [FIELD_W-1:0] vel_x;
    logic signed [FIELD_W-1:0] vel_y;
  } cell_out_t;

endpackage

[design/lbc_vel_div.sv]
module lbc_vel_div
  import lbc_pkg::*;
(
  input  logic clk,
  input  logic adv,
  input  logic signed [SUM_W-1:0] sum,
  input  logic signed [SUM_W-1:0] mx,
  input  logic signed [SUM_W-1:0] my,
  output field_t rho,
  output field_t ux,
  output field_t uy
);

  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam logic [QUO_W-1:0] QHALF = QUO_W'(1) << (QUO_W - 1);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] nb;
    logic             neg;
    logic             ovf;
  } dv_t;

  dv_t    st    [DIV_STAGES+1][2];
  dv_t    st_nx [DIV_STAGES][2];
  field_t rho_p [DIV_STAGES+1];

  dv_t              prep_c [2];
  field_t           rho_c;
  logic [REM_W-1:0] rho_u;

  // density saturation, sign split and first remainder
  always_comb begin
    logic signed [SUM_W-1:0] mom;
    logic signed [SUM_W-1:0] absv;
    logic [MAG_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    rho_c = sat_field(64'(sum));
    rho_u = rho_c;
    for (int c = 0; c < 2; c++) begin
      mom  = (c == 0) ? mx : my;
      absv = mom[SUM_W-1] ? -mom : mom;
      mag  = absv[MAG_W-1:0];
      num  = {mag, {FRAC_BITS{1'b0}}};
      prep_c[c].neg = mom[SUM_W-1];
      prep_c[c].rem = REM_W'(num[NUM_W-1:QUO_W]);
      prep_c[c].ovf = REM_W'(num[NUM_W-1:QUO_W]) >= rho_u;
      prep_c[c].nb  = num[QUO_W-1:0];
      prep_c[c].quo = '0;
    end
  end

  // restoring division, DIV_STEPS quotient bits per stage
  always_comb begin
    dv_t              cur;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] rs;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rs = rho_p[s];
      for (int c = 0; c < 2; c++) begin
        cur = st[s][c];
        for (int j = 0; j < DIV_STEPS; j++) begin
          sh     = {cur.rem[REM_W-2:0], cur.nb[QUO_W-1]};
          cur.nb = {cur.nb[QUO_W-2:0], 1'b0};
          if (sh >= rs) begin
            cur.rem = sh - rs;
            cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
          end else begin
            cur.rem = sh;
            cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
          end
        end
        st_nx[s][c] = cur;
      end
    end
  end

  // quotient sign and saturation
  function automatic field_t fin_vel(input dv_t d, input logic pos);
    field_t v;
    if (!pos) v = '0;
    else if (d.neg) v = (d.ovf || d.quo > QHALF) ? FIELD_MIN : field_t'(~d.quo + 1'b1);
    else v = (d.ovf || d.quo >= QHALF) ? FIELD_MAX : field_t'(d.quo);
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0]    <= prep_c;
      rho_p[0] <= rho_c;
      for (int s = 0; s < DIV_STAGES; s++) begin
        st[s+1]    <= st_nx[s];
        rho_p[s+1] <= rho_p[s];
      end
      rho <= rho_p[DIV_STAGES];
      ux  <= fin_vel(st[DIV_STAGES][0], rho_p[DIV_STAGES] > 0);
      uy  <= fin_vel(st[DIV_STAGES][1], rho_p[DIV_STAGES] > 0);
    end
  end

endmodule

[design/lbc_lane.sv]
module lbc_lane
  import lbc_pkg::*;
(
  input  logic clk,
  input  logic adv,
  input  wt_t wt,
  input  logic [RELAX_W-1:0] omega,
  input  logic signed [T3_W-1:0] t3,
  input  logic signed [E_W-1:0] nine_tsq,
  input  logic signed [E_W-1:0] u2x3,
  input  field_t rho,
  input  field_t f,
  output field_t post
);

  localparam int POLY_W = 34;
  localparam int PROD_W = FIELD_W + POLY_W;
  localparam int BASE_W = PROD_W - FRAC_BITS;
  localparam int XW     = BASE_W + 2;
  localparam int LO_W   = 19;
  localparam int A_W    = XW - LO_W;
  localparam int HI_M_W = 22;
  localparam int P1_W   = A_W + HI_M_W;
  localparam int Y_W    = 4 + LO_W;
  localparam int LO_M_W = 24;
  localparam int P2_W   = Y_W + LO_M_W;
  localparam int FEQ_W  = 33;
  localparam int DIFF_W = FEQ_W + 1;
  localparam int P3_W   = RELAX_W + 1 + DIFF_W;
  localparam int POST_W = 38;

  // exact divide by nine in two chunks: reciprocal multiply, then remainder
  localparam logic [HI_M_W-1:0] HI_M  = HI_M_W'(3728271);
  localparam int                HI_SH = A_W + 4;
  localparam logic [LO_M_W-1:0] LO_M  = LO_M_W'(14913081);
  localparam int                LO_SH = Y_W + 4;

  localparam logic signed [POLY_W-1:0] POLY_ONE = POLY_W'(1) <<< FRAC_BITS;
  localparam logic [31:0]   FEQ_LIM   = 32'h8000_0000;
  localparam logic [XW-1:0] FEQ_X_LIM = XW'(64'd9 << 31);

  field_t f_p [LANE_LAT-1];

  logic signed [POLY_W-1:0] l1_poly;
  field_t                   l1_rho;
  logic signed [PROD_W-1:0] l2_prod;
  logic                     l3_neg, l3_ovf;
  logic [XW-1:0]            l3_x;
  logic [P1_W-1:0]          l4_p1;
  logic [A_W-1:0]           l4_a;
  logic [LO_W-1:0]          l4_b;
  logic                     l4_neg, l4_ovf;
  logic [A_W-1:0]           l5_qh;
  logic [Y_W-1:0]           l5_y;
  logic                     l5_neg, l5_ovf;
  logic [P2_W-1:0]          l6_p2;
  logic [A_W-1:0]           l6_qh;
  logic                     l6_neg, l6_ovf;
  logic signed [FEQ_W-1:0]  l7_feq;
  logic signed [DIFF_W-1:0] l8_diff;
  logic signed [P3_W-1:0]   l9_p3;

  logic signed [E_W-1:0]    e_c, sh_c;
  logic signed [POLY_W-1:0] poly_c;
  logic signed [PROD_W-1:0] bsh_c;
  logic signed [BASE_W-1:0] base_c, absb_c;
  logic [BASE_W-1:0]        mag_c;
  logic [XW-1:0]            x_c;
  logic [P1_W-1:0]          qh_w_c;
  logic [A_W-1:0]           qh_c, rh_c;
  logic [P2_W-1:0]          ql_w_c;
  logic [A_W+LO_W-1:0]      q_c;
  logic [31:0]              magf_c;
  logic signed [FEQ_W-1:0]  feq_c;
  logic signed [P3_W-1:0]   rel_c;
  logic signed [POST_W-1:0] post_c;

  // equilibrium polynomial; stays far inside the clamp range by the field bounds
  always_comb begin
    e_c    = nine_tsq - u2x3;
    sh_c   = e_c >>> (FRAC_BITS + 1);
    poly_c = $signed(sh_c[POLY_W-1:0]) + POLY_W'(t3) + POLY_ONE;
  end

  // base value, weight scaling and feq overflow check
  always_comb begin
    bsh_c  = l2_prod >>> FRAC_BITS;
    base_c = bsh_c[BASE_W-1:0];
    absb_c = base_c[BASE_W-1] ? -base_c : base_c;
    mag_c  = absb_c;
    case (wt)
      WT_REST: x_c = {mag_c, 2'b00};
      WT_DIAG: x_c = XW'(mag_c >> 2);
      default: x_c = XW'(mag_c);
    endcase
  end

  // divide-by-nine chunks and feq sign
  always_comb begin
    qh_w_c = l4_p1 >> HI_SH;
    qh_c   = qh_w_c[A_W-1:0];
    rh_c   = l4_a - qh_c * A_W'(9);
    ql_w_c = l6_p2 >> LO_SH;
    q_c    = {l6_qh, ql_w_c[LO_W-1:0]};
    magf_c = l6_ovf ? FEQ_LIM : q_c[31:0];
    feq_c  = l6_neg ? -$signed({1'b0, magf_c}) : $signed({1'b0, magf_c});
  end

  // relaxation and saturation
  always_comb begin
    rel_c  = l9_p3 >>> FRAC_BITS;
    post_c = POST_W'(f_p[LANE_LAT-2]) + $signed(rel_c[POST_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_p[0] <= f;
      for (int i = 1; i < LANE_LAT - 1; i++) f_p[i] <= f_p[i-1];
      l1_poly <= poly_c;
      l1_rho  <= rho;
      l2_prod <= l1_rho * l1_poly;
      l3_neg  <= base_c[BASE_W-1];
      l3_x    <= x_c;
      l3_ovf  <= x_c >= FEQ_X_LIM;
      l4_p1   <= l3_x[XW-1:LO_W] * HI_M;
      l4_a    <= l3_x[XW-1:LO_W];
      l4_b    <= l3_x[LO_W-1:0];
      l4_neg  <= l3_neg;
      l4_ovf  <= l3_ovf;
      l5_qh   <= qh_c;
      l5_y    <= {rh_c[3:0], l4_b};
      l5_neg  <= l4_neg;
      l5_ovf  <= l4_ovf;
      l6_p2   <= l5_y * LO_M;
      l6_qh   <= l5_qh;
      l6_neg  <= l5_neg;
      l6_ovf  <= l5_ovf;
      l7_feq  <= feq_c;
      l8_diff <= DIFF_W'(l7_feq) - DIFF_W'(f_p[6]);
      l9_p3   <= $signed({1'b0, omega}) * l8_diff;
      post    <= sat_field(64'(post_c));
    end
  end

endmodule

[design/d2q9_bgk_cell_collision_core.sv]
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_data   (cell_in_t, nine distributions)
// out     | output    | out_valid/out_stall | out_data (cell_out_t, post values, rho, u)
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (relaxation rate)
//
// one cell per cycle while no result is held by out_stall; stages in order: moment sums, velocity
// divider (two quotient bits per stage), velocity squares, per-direction equilibrium
// and relaxation lanes.
// rst clears the valid pipeline and loads the default relaxation rate.
// out_stall with a result waiting freezes the whole pipeline; in_stall follows it.
module d2q9_bgk_cell_collision_core
  import lbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cell_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cell_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [RELAX_W-1:0]   cfg_data
);

  localparam int VLD_LEN = 1 + DIV_LAT + 3 + LANE_LAT;

  typedef struct packed {
    logic signed [FIELD_W-1:0] rho;
    logic signed [FIELD_W-1:0] ux;
    logic signed [FIELD_W-1:0] uy;
  } mom_t;

  logic               adv;
  logic [VLD_LEN-1:0] vld;
  logic [RELAX_W-1:0] relax_rate;

  dist_arr_t f_in;
  logic signed [SUM_W-1:0] sum_c, mx_c, my_c;

  dist_arr_t               s1_f;
  logic signed [SUM_W-1:0] s1_sum, s1_mx, s1_my;
  dist_arr_t               fdly [DIV_LAT];
  field_t                  div_rho, div_ux, div_uy;

  dist_arr_t              a_f;
  field_t                 a_rho, a_ux, a_uy;
  logic signed [VS_W-1:0] a_s, a_d;

  dist_arr_t              b_f;
  field_t                 b_rho, b_ux, b_uy;
  logic signed [VS_W-1:0] b_s, b_d;
  logic signed [SQ_W-1:0] b_sqx, b_sqy, b_sqs, b_sqd;

  dist_arr_t              c_f;
  mom_t                   c_mom;
  logic signed [T3_W-1:0] c_t3   [NDIR];
  logic signed [E_W-1:0]  c_nine [NDIR];
  logic signed [E_W-1:0]  c_u2x3;

  logic signed [T3_W-1:0] t3x_c, t3y_c, t3s_c, t3d_c;
  logic signed [E_W-1:0]  n9x_c, n9y_c, n9s_c, n9d_c, u2x3_c;

  mom_t   odly [LANE_LAT];
  field_t post [NDIR];

  // pipeline moves unless a result is held at the output
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[VLD_LEN-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      relax_rate <= RELAX_RESET;
    end else begin
      if (adv) vld <= {vld[VLD_LEN-2:0], in_valid};
      if (cfg_valid && cfg_ready) relax_rate <= cfg_data;
    end
  end

  // density and momentum sums
  always_comb begin
    f_in[DIR_REST]  = in_data.dist_rest;
    f_in[DIR_EAST]  = in_data.dist_east;
    f_in[DIR_WEST]  = in_data.dist_west;
    f_in[DIR_NORTH] = in_data.dist_north;
    f_in[DIR_SOUTH] = in_data.dist_south;
    f_in[DIR_NE]    = in_data.dist_ne;
    f_in[DIR_NW]    = in_data.dist_nw;
    f_in[DIR_SW]    = in_data.dist_sw;
    f_in[DIR_SE]    = in_data.dist_se;
    sum_c = '0;
    for (int k = 0; k < NDIR; k++) sum_c = sum_c + SUM_W'(f_in[k]);
    mx_c = SUM_W'(f_in[DIR_EAST]) - SUM_W'(f_in[DIR_WEST]) + SUM_W'(f_in[DIR_NE])
         - SUM_W'(f_in[DIR_NW]) - SUM_W'(f_in[DIR_SW]) + SUM_W'(f_in[DIR_SE]);
    my_c = SUM_W'(f_in[DIR_NORTH]) - SUM_W'(f_in[DIR_SOUTH]) + SUM_W'(f_in[DIR_NE])
         + SUM_W'(f_in[DIR_NW]) - SUM_W'(f_in[DIR_SW]) - SUM_W'(f_in[DIR_SE]);
  end

  lbc_vel_div u_div (
    .clk (clk),
    .adv (adv),
    .sum (s1_sum),
    .mx  (s1_mx),
    .my  (s1_my),
    .rho (div_rho),
    .ux  (div_ux),
    .uy  (div_uy)
  );

  // velocity terms per direction
  always_comb begin
    t3x_c  = T3_W'(b_ux) * T3_W'(3);
    t3y_c  = T3_W'(b_uy) * T3_W'(3);
    t3s_c  = T3_W'(b_s) * T3_W'(3);
    t3d_c  = T3_W'(b_d) * T3_W'(3);
    n9x_c  = E_W'(b_sqx) * E_W'(9);
    n9y_c  = E_W'(b_sqy) * E_W'(9);
    n9s_c  = E_W'(b_sqs) * E_W'(9);
    n9d_c  = E_W'(b_sqd) * E_W'(9);
    u2x3_c = (E_W'(b_sqx) + E_W'(b_sqy)) * E_W'(3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_f   <= f_in;
      s1_sum <= sum_c;
      s1_mx  <= mx_c;
      s1_my  <= my_c;
      fdly[0] <= s1_f;
      for (int i = 1; i < DIV_LAT; i++) fdly[i] <= fdly[i-1];
      // stage a: diagonal velocity sums
      a_f   <= fdly[DIV_LAT-1];
      a_rho <= div_rho;
      a_ux  <= div_ux;
      a_uy  <= div_uy;
      a_s   <= VS_W'(div_ux) + VS_W'(div_uy);
      a_d   <= VS_W'(div_ux) - VS_W'(div_uy);
      // stage b: squares
      b_f   <= a_f;
      b_rho <= a_rho;
      b_ux  <= a_ux;
      b_uy  <= a_uy;
      b_s   <= a_s;
      b_d   <= a_d;
      b_sqx <= a_ux * a_ux;
      b_sqy <= a_uy * a_uy;
      b_sqs <= a_s * a_s;
      b_sqd <= a_d * a_d;
      // stage c: per-direction 3t and 9t^2
      c_f       <= b_f;
      c_mom     <= '{rho: b_rho, ux: b_ux, uy: b_uy};
      c_u2x3    <= u2x3_c;
      c_t3[DIR_REST]  <= '0;
      c_t3[DIR_EAST]  <= t3x_c;
      c_t3[DIR_WEST]  <= -t3x_c;
      c_t3[DIR_NORTH] <= t3y_c;
      c_t3[DIR_SOUTH] <= -t3y_c;
      c_t3[DIR_NE]    <= t3s_c;
      c_t3[DIR_NW]    <= -t3d_c;
      c_t3[DIR_SW]    <= -t3s_c;
      c_t3[DIR_SE]    <= t3d_c;
      c_nine[DIR_REST]  <= '0;
      c_nine[DIR_EAST]  <= n9x_c;
      c_nine[DIR_WEST]  <= n9x_c;
      c_nine[DIR_NORTH] <= n9y_c;
      c_nine[DIR_SOUTH] <= n9y_c;
      c_nine[DIR_NE]    <= n9s_c;
      c_nine[DIR_NW]    <= n9d_c;
      c_nine[DIR_SW]    <= n9s_c;
      c_nine[DIR_SE]    <= n9d_c;
      // density and velocity ride along with the lanes
      odly[0] <= c_mom;
      for (int i = 1; i < LANE_LAT; i++) odly[i] <= odly[i-1];
    end
  end

  for (genvar k = 0; k < NDIR; k++) begin : g_lane
    lbc_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .wt       (lane_wt(k)),
      .omega    (relax_rate),
      .t3       (c_t3[k]),
      .nine_tsq (c_nine[k]),
      .u2x3     (c_u2x3),
      .rho      (c_mom.rho),
      .f        (c_f[k]),
      .post     (post[k])
    );
  end

  // result transfer
  always_comb begin
    out_data.post_rest  = post[DIR_REST];
    out_data.post_east  = post[DIR_EAST];
    out_data.post_west  = post[DIR_WEST];
    out_data.post_north = post[DIR_NORTH];
    out_data.post_south = post[DIR_SOUTH];
    out_data.post_ne    = post[DIR_NE];
    out_data.post_nw    = post[DIR_NW];
    out_data.post_sw    = post[DIR_SW];
    out_data.post_se    = post[DIR_SE];
    out_data.density    = odly[LANE_LAT-1].rho;
    out_data.vel_x      = odly[LANE_LAT-1].ux;
    out_data.vel_y      = odly[LANE_LAT-1].uy;
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lbc_pkg::*;

  localparam int NOUT       = 12;
  localparam int DRAIN_WAIT = 40;
  localparam logic [RELAX_W-1:0] RATE_ZERO = '0;
  localparam logic [RELAX_W-1:0] RATE_HALF = RELAX_W'(1048576);
  localparam logic [RELAX_W-1:0] RATE_TOP  = RELAX_W'(2097152);
  localparam field_t ONE = field_t'(1 << FRAC_BITS);
  localparam longint POLY_LIM = 64'sd549755813888;
  localparam longint FEQ_LIM  = 64'sd2147483648;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  cell_in_t in_data;
  logic out_valid;
  logic out_stall;
  cell_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [RELAX_W-1:0] cfg_data;

  d2q9_bgk_cell_collision_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // predictor state and bookkeeping
  logic [RELAX_W-1:0] omega_now;
  cell_out_t          expected_cells[$];
  int                 cells_taken;
  int                 rate_writes;
  int                 errors;
  bit                 quiet;
  bit                 typed_pending;
  cell_out_t          typed_result;

  const int dx[NDIR] = '{0, 1, -1, 0, 0, 1, -1, -1, 1};
  const int dy[NDIR] = '{0, 0, 0, 1, -1, 1, 1, -1, -1};
  const longint wnum[NDIR] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
  const longint wden[NDIR] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};
  const string out_names[NOUT] = '{"post_rest", "post_east", "post_west", "post_north",
    "post_south", "post_ne", "post_nw", "post_sw", "post_se", "density", "vel_x", "vel_y"};

  function automatic longint clip(longint x, longint lo, longint hi);
    longint r;
    r = x;
    if (x < lo) r = lo;
    if (x > hi) r = hi;
    return r;
  endfunction

  // bgk collision of one cell at the given relaxation rate
  function automatic cell_out_t collide_cell(cell_in_t c, logic [RELAX_W-1:0] om);
    longint f[NDIR];
    longint sum, mx, my, rho, ux, uy, u2, t, poly, base, feq, post, w;
    cell_out_t r;
    sum = 0; mx = 0; my = 0; ux = 0; uy = 0;
    w = longint'(om);
    for (int k = 0; k < NDIR; k++) begin
      f[k] = longint'($signed(c[(NDIR-1-k)*FIELD_W +: FIELD_W]));
      sum += f[k];
      mx += f[k] * dx[k];
      my += f[k] * dy[k];
    end
    rho = clip(sum, -8388608, 8388607);
    if (rho > 0) begin
      ux = clip((mx <<< FRAC_BITS) / rho, -8388608, 8388607);
      uy = clip((my <<< FRAC_BITS) / rho, -8388608, 8388607);
    end
    u2 = ux * ux + uy * uy;
    for (int k = 0; k < NDIR; k++) begin
      t = dx[k] * ux + dy[k] * uy;
      poly = (longint'(1) <<< FRAC_BITS) + 3 * t + ((9 * t * t - 3 * u2) >>> (FRAC_BITS + 1));
      poly = clip(poly, -POLY_LIM, POLY_LIM);
      base = (rho * poly) >>> FRAC_BITS;
      feq = clip((base * wnum[k]) / wden[k], -FEQ_LIM, FEQ_LIM);
      post = f[k] + ((w * (feq - f[k])) >>> FRAC_BITS);
      r[(NOUT-1-k)*FIELD_W +: FIELD_W] = FIELD_W'(clip(post, -8388608, 8388607));
    end
    r[2*FIELD_W +: FIELD_W] = FIELD_W'(rho);
    r[FIELD_W +: FIELD_W]   = FIELD_W'(ux);
    r[0 +: FIELD_W]         = FIELD_W'(uy);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // input and config transfers, predictor update
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      omega_now = cfg_data;
      rate_writes++;
    end
    if (!rst && in_valid && !in_stall) begin
      if (typed_pending) begin
        expected_cells.push_back(typed_result);
        typed_pending = 1'b0;
      end else begin
        expected_cells.push_back(collide_cell(in_data, omega_now));
      end
      cells_taken++;
    end
  end

  // result transfers checked field by field
  always @(posedge clk) begin
    cell_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_cells.pop_front();
        for (int k = 0; k < NOUT; k++)
          if (out_data[(NOUT-1-k)*FIELD_W +: FIELD_W] != want[(NOUT-1-k)*FIELD_W +: FIELD_W])
            report_mismatch(out_names[k],
                            $signed(out_data[(NOUT-1-k)*FIELD_W +: FIELD_W]),
                            $signed(want[(NOUT-1-k)*FIELD_W +: FIELD_W]));
      end
    end
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end
    end
  end

  task automatic write_rate(logic [RELAX_W-1:0] v);
    int target;
    target = rate_writes + 1;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (rate_writes < target);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_cell(cell_in_t c);
    int target;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    target = cells_taken + 1;
    in_valid <= 1'b1;
    in_data  <= c;
    do @(negedge clk); while (cells_taken < target);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    wait (expected_cells.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic field_t rand_field();
    return field_t'($urandom);
  endfunction

  // cell near equilibrium with random perturbation, or pure noise
  function automatic cell_in_t rand_cell();
    cell_in_t c;
    int spread;
    longint wt;
    spread = 1 << $urandom_range(4, 20);
    for (int k = 0; k < NDIR; k++) begin
      wt = (longint'(ONE) * wnum[k] * $urandom_range(1, 40)) / (wden[k] * 10);
      if ($urandom_range(0, 4) == 0)
        c[(NDIR-1-k)*FIELD_W +: FIELD_W] = rand_field();
      else
        c[(NDIR-1-k)*FIELD_W +: FIELD_W] =
          FIELD_W'(wt + longint'($urandom_range(0, 2 * spread)) - spread);
    end
    return c;
  endfunction

  typedef struct {
    cell_in_t  stim;
    bit        typed;
    cell_out_t result;
  } cell_row_t;

  // directed cells
  function automatic cell_row_t mk_row(field_t r, field_t e, field_t wv, field_t n, field_t s,
                                       field_t ne, field_t nw, field_t sw, field_t se);
    cell_row_t row;
    row.stim = {r, e, wv, n, s, ne, nw, sw, se};
    row.typed = 1'b0;
    row.result = '0;
    return row;
  endfunction

  initial begin
    cell_row_t rows[$];
    cell_row_t row;
    logic [RELAX_W-1:0] rates[5];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    omega_now = RELAX_RESET;
    cells_taken = 0;
    rate_writes = 0;
    errors = 0;
    quiet = 1'b0;
    typed_pending = 1'b0;
    typed_result = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // at reset rate: zero cell gives all zeros
    row = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.typed = 1'b1;
    rows.push_back(row);
    rows.push_back(mk_row(ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                          FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
    rows.push_back(mk_row(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
                          FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
    rows.push_back(mk_row(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX,
                          FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
    // density zero with momentum, and negative density
    rows.push_back(mk_row(0, ONE, -ONE, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-ONE, 0, 0, ONE >>> 2, 0, 0, 0, 0, 0));
    // tiny density, huge momentum: velocity saturates
    rows.push_back(mk_row(-FIELD_MAX + 1, FIELD_MAX, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(-FIELD_MAX + 1, 0, 0, 0, FIELD_MAX, 0, 0, 0, 0));
    rows.push_back(mk_row(1, 0, 0, 0, 0, 0, 0, FIELD_MAX, FIELD_MIN + 1));
    // equilibrium at rest, and moving cells
    rows.push_back(mk_row(466033, 116508, 116508, 116508, 116508, 29127, 29127, 29127, 29127));
    rows.push_back(mk_row(466033, 233016, 0, 116508, 116508, 58254, 0, 0, 58254));
    rows.push_back(mk_row(466033, 116508, 116508, 0, 233016, 0, 0, 58254, 58254));
    rows.push_back(mk_row(1, 1, 1, 1, 1, 1, 1, 1, 1));
    rows.push_back(mk_row(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    rows.push_back(mk_row(0, FIELD_MAX, 0, FIELD_MAX, 0, FIELD_MAX, 0, 0, 0));
    foreach (rows[i]) begin
      typed_pending = rows[i].typed;
      typed_result = rows[i].result;
      send_cell(rows[i].stim);
    end
    drain_pipe();

    // zero rate: posts equal inputs
    write_rate(RATE_ZERO);
    typed_pending = 1'b1;
    typed_result = '0;
    typed_result.post_rest = ONE;
    typed_result.density = ONE;
    send_cell({ONE, field_t'(0), field_t'(0), field_t'(0), field_t'(0),
               field_t'(0), field_t'(0), field_t'(0), field_t'(0)});
    for (int i = 0; i < 4; i++) send_cell(rows[i + 2].stim);
    drain_pipe();

    // random phases over several rates
    rates[0] = RATE_TOP;
    rates[1] = RATE_HALF;
    rates[2] = RELAX_W'($urandom_range(0, 2097152));
    rates[3] = RATE_ZERO;
    rates[4] = RELAX_RESET;
    for (int p = 0; p < 5; p++) begin
      write_rate(rates[p]);
      if (p == 4) quiet = 1'b1;
      for (int i = 0; i < 150; i++) begin
        if (p == 1 && i == 75) drain_pipe();
        send_cell(rand_cell());
      end
      drain_pipe();
    end

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
